FILE: rtl/llmm_pkg.sv
// ----------------------------------------------------------------------------
// llmm_pkg
// Shared types and constants of the linked-list multimap engine.
// ----------------------------------------------------------------------------
package llmm_pkg;

   localparam int KEY_SLOTS_DEFAULT   = 16;
   localparam int VALUE_SLOTS_DEFAULT = 64;
   localparam int MAX_RESULTS         = 64;
   localparam int COUNT_W             = 7;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_SIZE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

endpackage

FILE: rtl/llmm_if.sv
// ----------------------------------------------------------------------------
// llmm_req_if / llmm_rsp_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface llmm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic signed [31:0] key;
   logic signed [31:0] value;
   modport source (output valid, mode, key, value, input ready);
   modport sink   (input valid, mode, key, value, output ready);
endinterface

interface llmm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        has_value;
   logic signed [31:0] found_value;
   logic [6:0]  pair_count;
   logic        last;
   modport source (output valid, status, has_value, found_value, pair_count, last,
                   input ready);
   modport sink   (input valid, status, has_value, found_value, pair_count, last,
                   output ready);
endinterface

FILE: rtl/linked_list_multimap_engine.sv
// ----------------------------------------------------------------------------
// linked_list_multimap_engine
// Multimap of keys to value lists kept in array-linked pools with free lists.
// ----------------------------------------------------------------------------
// One request is taken at a time. A request other than size walks the key
// list one slot at a time (memory read, then compare); remove and lookup
// then walk the value list of the key the same way, through a single
// sequencer with registered memory reads. Lookup emits one response beat per
// value, and its walk waits while the response is stalled. After reset a
// clearing pass over the larger of KEY_SLOTS and VALUE_SLOTS chains the free
// lists; no request is taken meanwhile.
module linked_list_multimap_engine #(
   parameter int KEY_SLOTS   = llmm_pkg::KEY_SLOTS_DEFAULT,
   parameter int VALUE_SLOTS = llmm_pkg::VALUE_SLOTS_DEFAULT
) (
   input logic clock,
   input logic reset,
   llmm_req_if.sink   req,
   llmm_rsp_if.source rsp
);

   localparam int KW = $clog2(KEY_SLOTS + 1);
   localparam int VW = $clog2(VALUE_SLOTS + 1);
   localparam int KA = $clog2(KEY_SLOTS);
   localparam int VA = $clog2(VALUE_SLOTS);
   localparam int CW = llmm_pkg::COUNT_W;
   localparam int NW = $clog2(llmm_pkg::MAX_RESULTS + 1);
   localparam logic [KW-1:0] KNULL = KW'(KEY_SLOTS);
   localparam logic [VW-1:0] VNULL = VW'(VALUE_SLOTS);
   localparam int PW = (CW > VW) ? CW : VW;
   localparam int CLR_N = (KEY_SLOTS > VALUE_SLOTS) ? KEY_SLOTS : VALUE_SLOTS;
   localparam int CLW = $clog2(CLR_N + 1);

   typedef enum logic [12:0] {
      S_CLEAR  = 13'b0000000000001,
      S_IDLE   = 13'b0000000000010,
      S_KREAD  = 13'b0000000000100,
      S_KCMP   = 13'b0000000001000,
      S_DECIDE = 13'b0000000010000,
      S_VREAD  = 13'b0000000100000,
      S_VCMP   = 13'b0000001000000,
      S_UNLINK = 13'b0000010000000,
      S_KFREE  = 13'b0000100000000,
      S_NEWKEY = 13'b0001000000000,
      S_VPUT   = 13'b0010000000000,
      S_EMIT   = 13'b0100000000000,
      S_RESP   = 13'b1000000000000
   } state_type;

   logic signed [31:0] key_store       [KEY_SLOTS];
   logic [KW-1:0]      key_next_link   [KEY_SLOTS];
   logic [VW-1:0]      key_value_head  [KEY_SLOTS];
   logic signed [31:0] value_store     [VALUE_SLOTS];
   logic [VW-1:0]      value_next_link [VALUE_SLOTS];

   state_type state_ff, state_in;
   logic [KW-1:0] key_list_head_ff, key_list_head_in;
   logic [KW-1:0] key_free_head_ff, key_free_head_in;
   logic [VW-1:0] value_free_head_ff, value_free_head_in;
   logic [PW-1:0] stored_pairs_ff, stored_pairs_in;
   logic [CLW-1:0] clr_ff, clr_in;

   llmm_pkg::mode_type mode_ff, mode_in;
   logic signed [31:0] key_ff, key_in, value_ff, value_in;
   logic [KW-1:0] kcur_ff, kcur_in, kprev_ff, kprev_in;
   logic [KW-1:0] ksteps_ff, ksteps_in;
   logic [VW-1:0] vcur_ff, vcur_in, vprev_ff, vprev_in;
   logic [VW-1:0] vsteps_ff, vsteps_in;
   logic [NW-1:0] nout_ff, nout_in;

   // registered memory reads
   logic signed [31:0] rd_key_ff, rd_val_ff;
   logic [KW-1:0]      rd_knext_ff;
   logic [VW-1:0]      rd_khead_ff, rd_vnext_ff;
   logic [VW-1:0]      rd_vfnext_ff;
   logic [KW-1:0]      rd_kfnext_ff;

   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_has_ff, rsp_has_in, rsp_last_ff, rsp_last_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;

   // write ports
   logic kw_en; logic [KA-1:0] kw_a; logic signed [31:0] kw_key;
   logic [KW-1:0] kw_next; logic [VW-1:0] kw_head;
   logic kw_key_en, kw_next_en, kw_head_en;
   logic kn2_en; logic [KA-1:0] kn2_a; logic [KW-1:0] kn2_d;
   logic vw_en; logic [VA-1:0] vw_a; logic signed [31:0] vw_d;
   logic vn_en; logic [VA-1:0] vn_a; logic [VW-1:0] vn_d;
   logic vn2_en; logic [VA-1:0] vn2_a; logic [VW-1:0] vn2_d;

   logic [KA-1:0] kcur_a;
   logic [VA-1:0] vcur_a;
   logic [VA-1:0] vprev_a;
   assign kcur_a  = kcur_ff[KA-1:0];
   assign vcur_a  = vcur_ff[VA-1:0];
   assign vprev_a = vprev_ff[VA-1:0];

   always_ff @(posedge clock) begin
      rd_key_ff       <= key_store[kcur_a];
      rd_knext_ff     <= key_next_link[kcur_a];
      rd_khead_ff     <= key_value_head[kcur_a];
      rd_val_ff       <= value_store[vcur_a];
      rd_vnext_ff     <= value_next_link[vcur_a];
      rd_vfnext_ff    <= value_next_link[value_free_head_ff[VA-1:0]];
      rd_kfnext_ff    <= key_next_link[key_free_head_ff[KA-1:0]];
      if (kw_en && kw_key_en)  key_store[kw_a] <= kw_key;
      if (kw_en && kw_next_en) key_next_link[kw_a] <= kw_next;
      if (kw_en && kw_head_en) key_value_head[kw_a] <= kw_head;
      if (kn2_en) key_next_link[kn2_a] <= kn2_d;
      if (vw_en) value_store[vw_a] <= vw_d;
      if (vn_en) value_next_link[vn_a] <= vn_d;
      if (vn2_en) value_next_link[vn2_a] <= vn2_d;
   end

   logic [PW-1:0] pairs_wide;
   assign pairs_wide = stored_pairs_ff;

   always_comb begin
      state_in = state_ff;
      key_list_head_in = key_list_head_ff;
      key_free_head_in = key_free_head_ff;
      value_free_head_in = value_free_head_ff;
      stored_pairs_in = stored_pairs_ff;
      clr_in = clr_ff;
      mode_in = mode_ff; key_in = key_ff; value_in = value_ff;
      kcur_in = kcur_ff; kprev_in = kprev_ff; ksteps_in = ksteps_ff;
      vcur_in = vcur_ff; vprev_in = vprev_ff; vsteps_in = vsteps_ff;
      nout_in = nout_ff;
      rsp_status_in = rsp_status_ff; rsp_has_in = rsp_has_ff;
      rsp_last_in = rsp_last_ff; rsp_val_in = rsp_val_ff;
      kw_en = 1'b0; kw_a = kcur_a; kw_key = key_ff;
      kw_next = key_list_head_ff; kw_head = VNULL;
      kw_key_en = 1'b0; kw_next_en = 1'b0; kw_head_en = 1'b0;
      kn2_en = 1'b0; kn2_a = kprev_ff[KA-1:0]; kn2_d = rd_knext_ff;
      vw_en = 1'b0; vw_a = value_free_head_ff[VA-1:0]; vw_d = value_ff;
      vn_en = 1'b0; vn_a = value_free_head_ff[VA-1:0]; vn_d = rd_khead_ff;
      vn2_en = 1'b0; vn2_a = vprev_a; vn2_d = rd_vnext_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff < CLW'(VALUE_SLOTS)) begin
               vn_en = 1'b1; vn_a = clr_ff[VA-1:0];
               vn_d = VW'(clr_ff) + VW'(1);
            end
            if (clr_ff < CLW'(KEY_SLOTS)) begin
               kn2_en = 1'b1; kn2_a = clr_ff[KA-1:0];
               kn2_d = KW'(clr_ff) + KW'(1);
            end
            clr_in = clr_ff + CLW'(1);
            if (clr_ff == CLW'(CLR_N - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               mode_in = llmm_pkg::mode_type'(req.mode);
               key_in = req.key; value_in = req.value;
               kcur_in = key_list_head_ff; kprev_in = KNULL;
               ksteps_in = '0; nout_in = '0;
               if (llmm_pkg::mode_type'(req.mode) == llmm_pkg::MODE_SIZE) begin
                  rsp_status_in = llmm_pkg::ST_OK; rsp_has_in = 1'b0;
                  rsp_val_in = '0; rsp_last_in = 1'b1; state_in = S_RESP;
               end else begin
                  state_in = S_KREAD;
               end
            end
         end
         S_KREAD: begin
            if (kcur_ff >= KNULL || ksteps_ff >= KNULL) state_in = S_DECIDE;
            else state_in = S_KCMP;
         end
         S_KCMP: begin
            if (rd_key_ff == key_ff) begin
               state_in = S_DECIDE;
            end else begin
               kprev_in = kcur_ff; kcur_in = rd_knext_ff;
               ksteps_in = ksteps_ff + KW'(1); state_in = S_KREAD;
            end
         end
         S_DECIDE: begin
            // kcur < KNULL and ksteps < KNULL here mean the key was found (rd_* hold its slot)
            rsp_has_in = 1'b0; rsp_val_in = '0; rsp_last_in = 1'b1;
            vcur_in = rd_khead_ff; vprev_in = VNULL; vsteps_in = '0;
            case (mode_ff)
               llmm_pkg::MODE_INSERT: begin
                  if (value_free_head_ff >= VNULL) begin
                     rsp_status_in = llmm_pkg::ST_FULL; state_in = S_RESP;
                  end else if (kcur_ff >= KNULL || ksteps_ff >= KNULL) begin
                     if (key_free_head_ff >= KNULL) begin
                        rsp_status_in = llmm_pkg::ST_FULL; state_in = S_RESP;
                     end else begin
                        state_in = S_NEWKEY;
                     end
                  end else begin
                     state_in = S_VPUT;
                  end
               end
               default: begin
                  if (kcur_ff >= KNULL || ksteps_ff >= KNULL) begin
                     rsp_status_in = llmm_pkg::ST_NOTFOUND; state_in = S_RESP;
                  end else begin
                     state_in = S_VREAD;
                  end
               end
            endcase
         end
         S_NEWKEY: begin
            kw_en = 1'b1; kw_a = key_free_head_ff[KA-1:0];
            kw_key_en = 1'b1; kw_next_en = 1'b1; kw_head_en = 1'b1;
            kw_next = key_list_head_ff; kw_head = VNULL;
            key_free_head_in = rd_kfnext_ff;
            key_list_head_in = key_free_head_ff;
            kcur_in = key_free_head_ff;
            vcur_in = VNULL;
            state_in = S_VPUT;
         end
         S_VPUT: begin
            // head of the key: VNULL for a new key, else the read head
            vw_en = 1'b1; vn_en = 1'b1;
            vn_d = vcur_ff;
            kw_en = 1'b1; kw_a = kcur_a; kw_head_en = 1'b1;
            kw_head = value_free_head_ff;
            value_free_head_in = rd_vfnext_ff;
            stored_pairs_in = stored_pairs_ff + PW'(1);
            rsp_status_in = llmm_pkg::ST_OK; state_in = S_RESP;
         end
         S_VREAD: begin
            if (vcur_ff >= VNULL || vsteps_ff >= VNULL ||
                (mode_ff == llmm_pkg::MODE_LOOKUP &&
                 nout_ff >= NW'(llmm_pkg::MAX_RESULTS))) begin
               if (mode_ff == llmm_pkg::MODE_LOOKUP && nout_ff != '0) begin
                  rsp_status_in = llmm_pkg::ST_OK; rsp_has_in = 1'b1;
                  rsp_last_in = 1'b1; state_in = S_RESP;
               end else begin
                  rsp_status_in = llmm_pkg::ST_NOTFOUND; rsp_has_in = 1'b0;
                  rsp_val_in = '0; rsp_last_in = 1'b1; state_in = S_RESP;
               end
            end else begin
               state_in = S_VCMP;
            end
         end
         S_VCMP: begin
            if (mode_ff == llmm_pkg::MODE_LOOKUP) begin
               // hold previous value beat until the next one is known
               if (nout_ff != '0) begin
                  rsp_last_in = 1'b0; state_in = S_EMIT;
               end else begin
                  rsp_status_in = llmm_pkg::ST_OK; rsp_has_in = 1'b1;
                  rsp_val_in = rd_val_ff;
                  nout_in = nout_ff + NW'(1);
                  vcur_in = rd_vnext_ff; vsteps_in = vsteps_ff + VW'(1);
                  state_in = S_VREAD;
               end
            end else if (rd_val_ff == value_ff) begin
               state_in = S_UNLINK;
            end else begin
               vprev_in = vcur_ff; vcur_in = rd_vnext_ff;
               vsteps_in = vsteps_ff + VW'(1); state_in = S_VREAD;
            end
         end
         S_EMIT: begin
            rsp_status_in = llmm_pkg::ST_OK; rsp_has_in = 1'b1;
            if (rsp.ready) begin
               rsp_val_in = rd_val_ff;
               nout_in = nout_ff + NW'(1);
               vcur_in = rd_vnext_ff; vsteps_in = vsteps_ff + VW'(1);
               state_in = S_VREAD;
            end
         end
         S_UNLINK: begin
            if (vprev_ff < VNULL) begin
               vn2_en = 1'b1; vn2_a = vprev_a; vn2_d = rd_vnext_ff;
            end else begin
               kw_en = 1'b1; kw_a = kcur_a; kw_head_en = 1'b1;
               kw_head = rd_vnext_ff;
            end
            vn_en = 1'b1; vn_a = vcur_a; vn_d = value_free_head_ff;
            value_free_head_in = vcur_ff;
            if (stored_pairs_ff != '0) stored_pairs_in = stored_pairs_ff - PW'(1);
            rsp_status_in = llmm_pkg::ST_OK;
            if (vprev_ff >= VNULL && rd_vnext_ff >= VNULL) state_in = S_KFREE;
            else state_in = S_RESP;
         end
         S_KFREE: begin
            if (kprev_ff < KNULL) begin
               kn2_en = 1'b1; kn2_a = kprev_ff[KA-1:0]; kn2_d = rd_knext_ff;
            end else begin
               key_list_head_in = rd_knext_ff;
            end
            kw_en = 1'b1; kw_a = kcur_a; kw_next_en = 1'b1;
            kw_next = key_free_head_ff;
            key_free_head_in = kcur_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         key_list_head_ff <= KNULL;
         key_free_head_ff <= '0;
         value_free_head_ff <= '0;
         stored_pairs_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         key_list_head_ff <= key_list_head_in;
         key_free_head_ff <= key_free_head_in;
         value_free_head_ff <= value_free_head_in;
         stored_pairs_ff <= stored_pairs_in;
      end
      mode_ff <= mode_in; key_ff <= key_in; value_ff <= value_in;
      kcur_ff <= kcur_in; kprev_ff <= kprev_in; ksteps_ff <= ksteps_in;
      vcur_ff <= vcur_in; vprev_ff <= vprev_in; vsteps_ff <= vsteps_in;
      nout_ff <= nout_in;
      rsp_status_ff <= rsp_status_in; rsp_has_ff <= rsp_has_in;
      rsp_last_ff <= rsp_last_in; rsp_val_ff <= rsp_val_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP) || (state_ff == S_EMIT);
   assign rsp.status = rsp_status_ff;
   assign rsp.has_value = rsp_has_ff;
   assign rsp.found_value = rsp_val_ff;
   assign rsp.last = (state_ff == S_EMIT) ? 1'b0 : rsp_last_ff;
   assign rsp.pair_count = (pairs_wide > PW'(127)) ? 7'd127 : 7'(stored_pairs_ff);

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_emit_value: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> rsp.has_value && !rsp.last)
      else $error("lookup beat malformed");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.found_value))
      else $error("response dropped");
   a_pairs: assert property (@(posedge clock) disable iff (reset)
      pairs_wide <= PW'(VALUE_SLOTS)) else $error("pair count overflow");

endmodule

FILE: tb/sv/tb_linked_list_multimap_engine.sv
// ----------------------------------------------------------------------------
// tb_linked_list_multimap_engine
// Drives insert, remove, lookup and size requests into the multimap engine,
// predicts every response beat with a model of the key and value pools, and
// compares each accepted beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_linked_list_multimap_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KSLOTS = llmm_pkg::KEY_SLOTS_DEFAULT;
   localparam int VSLOTS = llmm_pkg::VALUE_SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      llmm_pkg::status_type status;
      logic        has_value;
      logic [31:0] found_value;
      logic [6:0]  pair_count;
      logic        last;
   } beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   llmm_req_if req ();
   llmm_rsp_if rsp ();

   linked_list_multimap_engine DUT (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   // multimap model state
   logic [31:0] mm_key    [KSLOTS];
   int          mm_knext  [KSLOTS];
   int          mm_vhead  [KSLOTS];
   int          mm_khead;
   int          mm_kfree;
   logic [31:0] mm_val    [VSLOTS];
   int          mm_vnext  [VSLOTS];
   int          mm_vfree;
   int          mm_pairs;

   beat_type pending_beats[$];
   logic [31:0] live_keys[$];
   int   failures = 0;
   int   cycles = 0;
   logic hold_off = 1'b0;
   int   hold_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("linked_list_multimap_engine regression: fail");
         $finish;
      end
   end

   function automatic int find_slot(logic [31:0] k, output int prev);
      int cur;
      int bef;
      cur = mm_khead;
      bef = KSLOTS;
      prev = KSLOTS;
      for (int s = 0; s < KSLOTS && cur < KSLOTS; s++) begin
         if (mm_key[cur] == k) begin
            prev = bef;
            return cur;
         end
         bef = cur;
         cur = mm_knext[cur];
      end
      return KSLOTS;
   endfunction

   function automatic beat_type mk_beat(llmm_pkg::status_type st, logic hv, logic [31:0] v,
                                        logic lst);
      beat_type b;
      b.status = st;
      b.has_value = hv;
      b.found_value = v;
      b.pair_count = (mm_pairs > 127) ? 7'd127 : mm_pairs[6:0];
      b.last = lst;
      return b;
   endfunction

   function automatic void add_beat(beat_type b);
      pending_beats = {pending_beats, b};
   endfunction

   task automatic predict_request(llmm_pkg::mode_type md, logic [31:0] k, logic [31:0] v);
      int slot;
      int prev;
      int vs;
      int cur;
      int bef;
      int n;
      llmm_pkg::status_type st;
      slot = find_slot(k, prev);
      case (md)
         llmm_pkg::MODE_INSERT: begin
            st = llmm_pkg::ST_OK;
            if (mm_vfree >= VSLOTS) st = llmm_pkg::ST_FULL;
            else if (slot >= KSLOTS && mm_kfree >= KSLOTS) st = llmm_pkg::ST_FULL;
            else begin
               if (slot >= KSLOTS) begin
                  slot = mm_kfree;
                  mm_kfree = mm_knext[slot];
                  mm_key[slot] = k;
                  mm_knext[slot] = mm_khead;
                  mm_khead = slot;
                  mm_vhead[slot] = VSLOTS;
               end
               vs = mm_vfree;
               mm_vfree = mm_vnext[vs];
               mm_val[vs] = v;
               mm_vnext[vs] = mm_vhead[slot];
               mm_vhead[slot] = vs;
               mm_pairs++;
            end
            add_beat(mk_beat(st, 1'b0, 32'd0, 1'b1));
         end
         llmm_pkg::MODE_REMOVE: begin
            st = llmm_pkg::ST_NOTFOUND;
            if (slot < KSLOTS) begin
               cur = mm_vhead[slot];
               bef = VSLOTS;
               while (cur < VSLOTS && mm_val[cur] != v) begin
                  bef = cur;
                  cur = mm_vnext[cur];
               end
               if (cur < VSLOTS) begin
                  st = llmm_pkg::ST_OK;
                  if (bef < VSLOTS) mm_vnext[bef] = mm_vnext[cur];
                  else mm_vhead[slot] = mm_vnext[cur];
                  mm_vnext[cur] = mm_vfree;
                  mm_vfree = cur;
                  if (mm_pairs > 0) mm_pairs--;
                  if (mm_vhead[slot] >= VSLOTS) begin
                     if (prev < KSLOTS) mm_knext[prev] = mm_knext[slot];
                     else mm_khead = mm_knext[slot];
                     mm_knext[slot] = mm_kfree;
                     mm_kfree = slot;
                  end
               end
            end
            add_beat(mk_beat(st, 1'b0, 32'd0, 1'b1));
         end
         llmm_pkg::MODE_LOOKUP: begin
            n = 0;
            if (slot < KSLOTS) begin
               cur = mm_vhead[slot];
               while (cur < VSLOTS && n < llmm_pkg::MAX_RESULTS) begin
                  n++;
                  add_beat(mk_beat(llmm_pkg::ST_OK, 1'b1, mm_val[cur],
                     (mm_vnext[cur] >= VSLOTS || n == llmm_pkg::MAX_RESULTS)));
                  cur = mm_vnext[cur];
               end
            end
            if (n == 0) add_beat(mk_beat(llmm_pkg::ST_NOTFOUND, 1'b0, 32'd0, 1'b1));
         end
         default: add_beat(mk_beat(llmm_pkg::ST_OK, 1'b0, 32'd0, 1'b1));
      endcase
   endtask

   // sender: one request beat, bursts with random gaps
   int burst_left = 0;

   task automatic send_request(llmm_pkg::mode_type md, logic [31:0] k, logic [31:0] v);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req.valid <= 1'b1;
      req.mode <= md;
      req.key <= k;
      req.value <= v;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_request(md, k, v);
   endtask

   task automatic drain_all();
      req.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // receiver stall pattern plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_off || hold_cycles != 0) begin
         rsp.ready <= 1'b0;
         hold_cycles <= hold_off ? 400 : hold_cycles - 1;
      end else begin
         rsp.ready <= (cycles % 37 < 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      beat_type exp_b;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_beats.size() == 0) begin
            $error("response beat with nothing expected");
            failures++;
         end else begin
            exp_b = pending_beats.pop_front();
            if (rsp.status !== exp_b.status) begin
               $error("status exp %0d got %0d", exp_b.status, rsp.status);
               failures++;
            end
            if (rsp.has_value !== exp_b.has_value) begin
               $error("has_value exp %0d got %0d", exp_b.has_value, rsp.has_value);
               failures++;
            end
            if (rsp.found_value !== exp_b.found_value) begin
               $error("found_value exp %0h got %0h", exp_b.found_value, rsp.found_value);
               failures++;
            end
            if (rsp.pair_count !== exp_b.pair_count) begin
               $error("pair_count exp %0d got %0d", exp_b.pair_count, rsp.pair_count);
               failures++;
            end
            if (rsp.last !== exp_b.last) begin
               $error("last exp %0d got %0d", exp_b.last, rsp.last);
               failures++;
            end
         end
      end
   end

   function automatic logic [31:0] pick_key();
      if (live_keys.size() != 0 && $urandom_range(0, 3) != 0)
         return live_keys[$urandom_range(0, live_keys.size() - 1)];
      return $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 20);
   endfunction

   task automatic test_directed();
      send_request(llmm_pkg::MODE_SIZE, 32'h0, 32'h0);
      send_request(llmm_pkg::MODE_LOOKUP, 32'h8000_0000, 32'h0);
      send_request(llmm_pkg::MODE_REMOVE, 32'h7fff_ffff, 32'h1);
      send_request(llmm_pkg::MODE_INSERT, 32'h8000_0000, 32'h7fff_ffff);
      send_request(llmm_pkg::MODE_INSERT, 32'h8000_0000, 32'h8000_0000);
      send_request(llmm_pkg::MODE_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
      send_request(llmm_pkg::MODE_INSERT, 32'h0, 32'h0);
      send_request(llmm_pkg::MODE_LOOKUP, 32'h8000_0000, 32'h0);
      send_request(llmm_pkg::MODE_REMOVE, 32'h8000_0000, 32'h5);
      send_request(llmm_pkg::MODE_REMOVE, 32'h8000_0000, 32'h7fff_ffff);
      send_request(llmm_pkg::MODE_REMOVE, 32'h8000_0000, 32'h8000_0000);
      send_request(llmm_pkg::MODE_LOOKUP, 32'h8000_0000, 32'hffff_ffff);
      send_request(llmm_pkg::MODE_SIZE, 32'hffff_ffff, 32'hffff_ffff);
      send_request(llmm_pkg::MODE_REMOVE, 32'h7fff_ffff, 32'hffff_ffff);
      send_request(llmm_pkg::MODE_REMOVE, 32'h0, 32'h0);
      drain_all();
   endtask

   task automatic test_key_pool_full();
      for (int i = 0; i < KSLOTS + 2; i++) send_request(llmm_pkg::MODE_INSERT, i, i);
      send_request(llmm_pkg::MODE_SIZE, 0, 0);
      for (int i = 0; i < KSLOTS; i++) send_request(llmm_pkg::MODE_REMOVE, i, i);
      drain_all();
      for (int i = 0; i < 4; i++) send_request(llmm_pkg::MODE_LOOKUP, i, 0);
      drain_all();
   endtask

   task automatic test_value_pool_full_and_long_lookup();
      logic [31:0] v;
      for (int i = 0; i < VSLOTS + 1; i++) send_request(llmm_pkg::MODE_INSERT, 32'h55, i);
      send_request(llmm_pkg::MODE_INSERT, 32'h66, 1);
      send_request(llmm_pkg::MODE_LOOKUP, 32'h55, 0);
      send_request(llmm_pkg::MODE_SIZE, 0, 0);
      for (int i = 0; i < VSLOTS; i++) begin
         v = (i * 37) % VSLOTS;
         send_request(llmm_pkg::MODE_REMOVE, 32'h55, v);
      end
      drain_all();
   endtask

   task automatic test_backpressure();
      hold_off <= 1'b1;
      @(posedge clock);
      hold_off <= 1'b0;
      for (int i = 0; i < 6; i++) send_request(llmm_pkg::MODE_INSERT, 32'h10, i);
      req.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      send_request(llmm_pkg::MODE_LOOKUP, 32'h10, 0);
      for (int i = 0; i < 6; i++) send_request(llmm_pkg::MODE_REMOVE, 32'h10, i);
      drain_all();
   endtask

   task automatic test_random();
      logic [31:0] k;
      int r;
      for (int i = 0; i < 24; i++) begin
         k = pick_key();
         r = $urandom_range(0, 9);
         if (r < 4) begin
            if (live_keys.size() < 24) live_keys = {live_keys, k};
            send_request(llmm_pkg::MODE_INSERT, k,
                         $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 3));
         end else if (r < 7) begin
            send_request(llmm_pkg::MODE_REMOVE, k,
                         $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 3));
         end else if (r < 9) begin
            send_request(llmm_pkg::MODE_LOOKUP, k, $urandom());
         end else begin
            send_request(llmm_pkg::MODE_SIZE, $urandom(), $urandom());
         end
      end
      drain_all();
   endtask

   initial begin
      req.valid = 1'b0;
      req.mode = llmm_pkg::MODE_SIZE;
      req.key = '0;
      req.value = '0;
      mm_khead = KSLOTS;
      mm_kfree = 0;
      mm_vfree = 0;
      mm_pairs = 0;
      for (int i = 0; i < KSLOTS; i++) begin
         mm_key[i] = '0;
         mm_knext[i] = i + 1;
         mm_vhead[i] = 0;
      end
      for (int i = 0; i < VSLOTS; i++) begin
         mm_val[i] = '0;
         mm_vnext[i] = i + 1;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_key_pool_full();
      test_value_pool_full_and_long_lookup();
      test_backpressure();
      test_random();
      if (failures == 0) begin
         $display("linked_list_multimap_engine regression: pass");
      end else begin
         $display("linked_list_multimap_engine regression: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/llmm_pkg.sv
rtl/llmm_if.sv
rtl/linked_list_multimap_engine.sv
tb/sv/tb_linked_list_multimap_engine.sv
